[sv/hrt_pkg.sv]
package hrt_pkg;

  typedef enum logic [2:0] {
    PH_METHOD = 3'd0,
    PH_URI    = 3'd1,
    PH_PROTO  = 3'd2,
    PH_MAJOR  = 3'd3,
    PH_MINOR  = 3'd4,
    PH_KEY    = 3'd5,
    PH_VALUE  = 3'd6,
    PH_BODY   = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    STG_SKIP   = 2'd0,
    STG_SIGN   = 2'd1,
    STG_DIGITS = 2'd2,
    STG_STOP   = 2'd3
  } num_stage_t;

  typedef logic [7:0] byte_t;

  localparam logic [2:0] KIND_DELIM  = 3'd0;
  localparam logic [2:0] KIND_METHOD = 3'd1;
  localparam logic [2:0] KIND_PATH   = 3'd2;
  localparam logic [2:0] KIND_QUERY  = 3'd3;
  localparam logic [2:0] KIND_PROTO  = 3'd4;
  localparam logic [2:0] KIND_KEY    = 3'd5;
  localparam logic [2:0] KIND_VALUE  = 3'd6;
  localparam logic [2:0] KIND_BODY   = 3'd7;

  localparam logic [2:0] END_METHOD = 3'd0;
  localparam logic [2:0] END_URI    = 3'd1;
  localparam logic [2:0] END_PROTO  = 3'd2;
  localparam logic [2:0] END_MAJOR  = 3'd3;
  localparam logic [2:0] END_MINOR  = 3'd4;
  localparam logic [2:0] END_KEY    = 3'd5;
  localparam logic [2:0] END_VALUE  = 3'd6;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BARE_LF = 2'd1;
  localparam logic [1:0] STAT_BAD_EOL = 2'd2;

  localparam byte_t CH_SPACE = 8'h20;
  localparam byte_t CH_SLASH = 8'h2F;
  localparam byte_t CH_DOT   = 8'h2E;
  localparam byte_t CH_COLON = 8'h3A;
  localparam byte_t CH_CR    = 8'h0D;
  localparam byte_t CH_LF    = 8'h0A;
  localparam byte_t CH_TAB   = 8'h09;
  localparam byte_t CH_VT    = 8'h0B;
  localparam byte_t CH_FF    = 8'h0C;
  localparam byte_t CH_PLUS  = 8'h2B;
  localparam byte_t CH_QMARK = 8'h3F;
  localparam byte_t CH_ZERO  = 8'h30;
  localparam byte_t CH_NINE  = 8'h39;

endpackage

[sv/http_request_tokenizer.sv]
// Output: each accepted beat is registered before it is presented at the output.
// Throughput: one byte per cycle; the parse state updates in the accept cycle and a single
// output register holds the result, so input is taken while out_ready is high or the
// output register is empty.
// Reset: synchronous active-low rst_n returns the parser to the method phase with all
// flags and the version accumulator cleared, and empties the output register.
module http_request_tokenizer #(
  parameter int VERSION_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hrt_pkg::byte_t     in_data_byte,
  input  logic               in_first_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output hrt_pkg::byte_t     out_byte,
  output logic [2:0]         out_byte_kind,
  output logic               out_field_end,
  output logic [2:0]         out_ended_field,
  output logic [7:0]         out_version_number,
  output logic               out_headers_done,
  output logic [1:0]         out_status
);
  import hrt_pkg::*;

  localparam int VW = VERSION_BITS + 4;
  localparam int RW = (VERSION_BITS > 8) ? VERSION_BITS : 8;
  localparam logic [VERSION_BITS-1:0] VMAX = {VERSION_BITS{1'b1}};

  phase_t                  phase_r, phase_nxt, ph;
  logic                    cr_r, cr_nxt, cr;
  logic                    query_r, query_nxt, qry;
  logic [VERSION_BITS-1:0] acc_r, acc_nxt, acc;
  num_stage_t              stg_r, stg_nxt, stg;

  logic                    out_valid_r, out_valid_nxt;
  byte_t                   out_byte_r;
  logic [2:0]              kind_r, kind_nxt;
  logic                    fend_r, fend_nxt;
  logic [2:0]              which_r, which_nxt;
  logic [7:0]              ver_r, ver_nxt;
  logic                    hdone_r, hdone_nxt;
  logic [1:0]              stat_r, stat_nxt;

  logic                    accept;
  logic                    is_digit;
  logic [VW-1:0]           acc_mul;
  logic [RW-1:0]           acc_ext;
  logic [7:0]              report;
  byte_t                   b;

  assign b        = in_data_byte;
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // current state, with restart applied before the byte
  always_comb begin
    if (in_first_byte) begin
      ph  = PH_METHOD;
      cr  = 1'b0;
      qry = 1'b0;
      acc = '0;
      stg = STG_SKIP;
    end else begin
      ph  = phase_r;
      cr  = cr_r;
      qry = query_r;
      acc = acc_r;
      stg = stg_r;
    end
  end

  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign acc_mul  = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + VW'(b - CH_ZERO);
  assign acc_ext  = RW'(acc);
  assign report   = (acc_ext > RW'(255)) ? 8'hFF : acc_ext[7:0];

  always_comb begin
    phase_nxt = ph;
    cr_nxt    = cr;
    query_nxt = qry;
    acc_nxt   = acc;
    stg_nxt   = stg;
    kind_nxt  = KIND_DELIM;
    fend_nxt  = 1'b0;
    which_nxt = END_METHOD;
    ver_nxt   = 8'd0;
    hdone_nxt = 1'b0;
    stat_nxt  = STAT_OK;
    priority if (ph != PH_BODY && b == CH_CR) begin
      cr_nxt = 1'b1;
    end else if (ph != PH_BODY && b == CH_LF) begin
      cr_nxt = 1'b0;
      priority if (!cr) begin
        stat_nxt = STAT_BARE_LF;
      end else if (ph == PH_MINOR) begin
        fend_nxt  = 1'b1;
        which_nxt = END_MINOR;
        ver_nxt   = report;
        acc_nxt   = '0;
        stg_nxt   = STG_SKIP;
        phase_nxt = PH_KEY;
      end else if (ph == PH_VALUE) begin
        fend_nxt  = 1'b1;
        which_nxt = END_VALUE;
        phase_nxt = PH_KEY;
      end else if (ph == PH_KEY) begin
        hdone_nxt = 1'b1;
        phase_nxt = PH_BODY;
      end else begin
        stat_nxt = STAT_BAD_EOL;
      end
    end else begin
      unique case (ph)
        PH_METHOD: begin
          if (b == CH_SPACE) begin
            fend_nxt  = 1'b1;
            which_nxt = END_METHOD;
            phase_nxt = PH_URI;
          end else begin
            kind_nxt = KIND_METHOD;
          end
        end
        PH_URI: begin
          priority if (b == CH_SPACE) begin
            fend_nxt  = 1'b1;
            which_nxt = END_URI;
            query_nxt = 1'b0;
            phase_nxt = PH_PROTO;
          end else if (b == CH_QMARK && !qry) begin
            query_nxt = 1'b1;
          end else begin
            kind_nxt = qry ? KIND_QUERY : KIND_PATH;
          end
        end
        PH_PROTO: begin
          if (b == CH_SLASH) begin
            fend_nxt  = 1'b1;
            which_nxt = END_PROTO;
            acc_nxt   = '0;
            stg_nxt   = STG_SKIP;
            phase_nxt = PH_MAJOR;
          end else begin
            kind_nxt = KIND_PROTO;
          end
        end
        PH_MAJOR, PH_MINOR: begin
          if (ph == PH_MAJOR && b == CH_DOT) begin
            fend_nxt  = 1'b1;
            which_nxt = END_MAJOR;
            ver_nxt   = report;
            acc_nxt   = '0;
            stg_nxt   = STG_SKIP;
            phase_nxt = PH_MINOR;
          end else begin
            kind_nxt = KIND_PROTO;
            priority if (stg == STG_STOP) begin
              stg_nxt = STG_STOP;
            end else if (is_digit) begin
              acc_nxt = (acc_mul > VW'(VMAX)) ? VMAX : acc_mul[VERSION_BITS-1:0];
              stg_nxt = STG_DIGITS;
            end else if (stg == STG_SKIP) begin
              priority if (b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_FF) begin
                stg_nxt = STG_SKIP;
              end else if (b == CH_PLUS) begin
                stg_nxt = STG_SIGN;
              end else begin
                acc_nxt = '0;
                stg_nxt = STG_STOP;
              end
            end else begin
              if (stg == STG_SIGN) begin
                acc_nxt = '0;
              end
              stg_nxt = STG_STOP;
            end
          end
        end
        PH_KEY: begin
          if (b == CH_COLON) begin
            fend_nxt  = 1'b1;
            which_nxt = END_KEY;
            phase_nxt = PH_VALUE;
          end else begin
            kind_nxt = KIND_KEY;
          end
        end
        PH_VALUE: kind_nxt = KIND_VALUE;
        PH_BODY:  kind_nxt = KIND_BODY;
        default:  kind_nxt = KIND_BODY;
      endcase
    end
  end

  assign out_valid_nxt = accept || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_METHOD;
      cr_r        <= 1'b0;
      query_r     <= 1'b0;
      acc_r       <= '0;
      stg_r       <= STG_SKIP;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        phase_r <= phase_nxt;
        cr_r    <= cr_nxt;
        query_r <= query_nxt;
        acc_r   <= acc_nxt;
        stg_r   <= stg_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte_r <= b;
      kind_r     <= kind_nxt;
      fend_r     <= fend_nxt;
      which_r    <= which_nxt;
      ver_r      <= ver_nxt;
      hdone_r    <= hdone_nxt;
      stat_r     <= stat_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte           = out_byte_r;
  assign out_byte_kind      = kind_r;
  assign out_field_end      = fend_r;
  assign out_ended_field    = which_r;
  assign out_version_number = ver_r;
  assign out_headers_done   = hdone_r;
  assign out_status         = stat_r;

endmodule

[tb/http_request_tokenizer_tb.sv]
module http_request_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hrt_pkg::*;

  localparam int VERSION_BITS = 8;
  localparam int unsigned VERSION_MAX = (1 << VERSION_BITS) - 1;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    byte_t      data;
    logic [2:0] kind;
    logic       fend;
    logic [2:0] ended;
    logic [7:0] version;
    logic       hdone;
    logic [1:0] status;
  } token_t;

  typedef struct {
    byte_t b;
    bit    first;
  } beat_t;

  class token_scoreboard;
    phase_t      phase;
    bit          cr_seen;
    bit          in_query;
    int unsigned num_acc;
    num_stage_t  num_stage;
    token_t      expected_tokens[$];
    int          mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void clear_version();
      num_acc   = 0;
      num_stage = STG_SKIP;
    endfunction

    function void restart();
      phase    = PH_METHOD;
      cr_seen  = 1'b0;
      in_query = 1'b0;
      clear_version();
    endfunction

    function logic [7:0] cap_version();
      return (num_acc > 255) ? 8'hFF : num_acc[7:0];
    endfunction

    function void feed_version(byte_t b);
      if (num_stage == STG_STOP) return;
      if (b >= CH_ZERO && b <= CH_NINE) begin
        num_acc = num_acc * 10 + (b - CH_ZERO);
        if (num_acc > VERSION_MAX) num_acc = VERSION_MAX;
        num_stage = STG_DIGITS;
      end else if (num_stage == STG_SKIP) begin
        if (b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_FF) return;
        if (b == CH_PLUS) begin
          num_stage = STG_SIGN;
        end else begin
          num_acc   = 0;
          num_stage = STG_STOP;
        end
      end else begin
        if (num_stage == STG_SIGN) num_acc = 0;
        num_stage = STG_STOP;
      end
    endfunction

    // expected token for one accepted input beat
    function void tokenize(byte_t b, bit first);
      token_t t;
      t = '0;
      t.data = b;
      if (first) restart();
      if (phase != PH_BODY && b == CH_CR) begin
        cr_seen = 1'b1;
      end else if (phase != PH_BODY && b == CH_LF) begin
        if (!cr_seen) begin
          t.status = STAT_BARE_LF;
        end else begin
          case (phase)
            PH_MINOR: begin
              t.fend    = 1'b1;
              t.ended   = END_MINOR;
              t.version = cap_version();
              clear_version();
              phase = PH_KEY;
            end
            PH_VALUE: begin
              t.fend  = 1'b1;
              t.ended = END_VALUE;
              phase   = PH_KEY;
            end
            PH_KEY: begin
              t.hdone = 1'b1;
              phase   = PH_BODY;
            end
            default: t.status = STAT_BAD_EOL;
          endcase
        end
        cr_seen = 1'b0;
      end else begin
        case (phase)
          PH_METHOD: begin
            if (b == CH_SPACE) begin
              t.fend  = 1'b1;
              t.ended = END_METHOD;
              phase   = PH_URI;
            end else t.kind = KIND_METHOD;
          end
          PH_URI: begin
            if (b == CH_SPACE) begin
              t.fend   = 1'b1;
              t.ended  = END_URI;
              in_query = 1'b0;
              phase    = PH_PROTO;
            end else if (b == CH_QMARK && !in_query) begin
              in_query = 1'b1;
            end else t.kind = in_query ? KIND_QUERY : KIND_PATH;
          end
          PH_PROTO: begin
            if (b == CH_SLASH) begin
              t.fend  = 1'b1;
              t.ended = END_PROTO;
              clear_version();
              phase = PH_MAJOR;
            end else t.kind = KIND_PROTO;
          end
          PH_MAJOR: begin
            if (b == CH_DOT) begin
              t.fend    = 1'b1;
              t.ended   = END_MAJOR;
              t.version = cap_version();
              clear_version();
              phase = PH_MINOR;
            end else begin
              t.kind = KIND_PROTO;
              feed_version(b);
            end
          end
          PH_MINOR: begin
            t.kind = KIND_PROTO;
            feed_version(b);
          end
          PH_KEY: begin
            if (b == CH_COLON) begin
              t.fend  = 1'b1;
              t.ended = END_KEY;
              phase   = PH_VALUE;
            end else t.kind = KIND_KEY;
          end
          PH_VALUE: t.kind = KIND_VALUE;
          default:  t.kind = KIND_BODY;
        endcase
      end
      expected_tokens.push_back(t);
    endfunction

    function void check_beat(token_t got);
      token_t want;
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected output beat, byte %h", got.data);
        return;
      end
      want = expected_tokens.pop_front();
      if (got.data !== want.data || got.kind !== want.kind || got.fend !== want.fend ||
          got.ended !== want.ended || got.version !== want.version ||
          got.hdone !== want.hdone || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: exp byte=%h kind=%0d end=%0b/%0d ver=%0d hdone=%0b status=%0d",
                   want.data, want.kind, want.fend, want.ended, want.version, want.hdone,
                   want.status);
          $display("       got byte=%h kind=%0d end=%0b/%0d ver=%0d hdone=%0b status=%0d",
                   got.data, got.kind, got.fend, got.ended, got.version, got.hdone,
                   got.status);
        end
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  byte_t      in_data_byte = '0;
  logic       in_first_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  byte_t      out_byte;
  logic [2:0] out_byte_kind;
  logic       out_field_end;
  logic [2:0] out_ended_field;
  logic [7:0] out_version_number;
  logic       out_headers_done;
  logic [1:0] out_status;

  token_scoreboard sb;
  beat_t           request_beats[$];
  int              sent_cnt = 0;
  int              cycles = 0;
  int              hold_left = 0;
  bit              held = 1'b0;

  http_request_tokenizer #(.VERSION_BITS(VERSION_BITS)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_first_byte      (in_first_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte           (out_byte),
    .out_byte_kind      (out_byte_kind),
    .out_field_end      (out_field_end),
    .out_ended_field    (out_ended_field),
    .out_version_number (out_version_number),
    .out_headers_done   (out_headers_done),
    .out_status         (out_status)
  );

  always #4 clk = ~clk;

  function automatic bit calm();
    return sent_cnt >= 500 && sent_cnt < 760;
  endfunction

  function automatic void push(byte_t b, bit f = 1'b0);
    request_beats.push_back('{b, f});
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push(s[i]);
  endfunction

  function automatic byte_t any_except(byte_t x0, byte_t x1);
    byte_t b;
    do b = byte_t'($urandom_range(0, 255));
    while (b == CH_CR || b == CH_LF || b == x0 || b == x1);
    return b;
  endfunction

  function automatic byte_t text_byte(byte_t x0, byte_t x1);
    if ($urandom_range(0, 3) != 0) return byte_t'($urandom_range(97, 122));
    return any_except(x0, x1);
  endfunction

  function automatic byte_t digit();
    return byte_t'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  function automatic void put_version(byte_t stop);
    int n;
    case ($urandom_range(0, 7))
      0: push(digit());
      1: repeat ($urandom_range(1, 3)) push(digit());
      2: begin
        repeat ($urandom_range(1, 3)) begin
          n = $urandom_range(0, 3);
          push(n == 0 ? CH_SPACE : n == 1 ? CH_TAB : n == 2 ? CH_VT : CH_FF);
        end
        if ($urandom_range(0, 1) != 0) push(CH_PLUS);
        repeat ($urandom_range(1, 2)) push(digit());
      end
      3: begin
        push(CH_PLUS);
        if ($urandom_range(0, 1) != 0) push(any_except(stop, CH_ZERO));
        repeat ($urandom_range(0, 2)) push(digit());
      end
      4: begin
        push("-");
        repeat ($urandom_range(1, 2)) push(digit());
      end
      5: repeat ($urandom_range(4, 6)) push(digit());
      6: ;
      default: begin
        push(digit());
        push(any_except(stop, CH_PLUS));
        push(digit());
      end
    endcase
  endfunction

  function automatic void add_request(bit restart);
    int start;
    int k;
    int n;
    start = request_beats.size();
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) push(text_byte(CH_SPACE, CH_SPACE), restart && i == 0);
    push(CH_SPACE);
    push(CH_SLASH);
    repeat ($urandom_range(0, 8)) begin
      if ($urandom_range(0, 6) == 0) push(CH_QMARK);
      else push(text_byte(CH_SPACE, CH_SPACE));
    end
    push(CH_SPACE);
    if ($urandom_range(0, 1) != 0) push_text("HTTP");
    else repeat ($urandom_range(0, 4)) push(text_byte(CH_SLASH, CH_SLASH));
    push(CH_SLASH);
    put_version(CH_DOT);
    push(CH_DOT);
    put_version(CH_CR);
    push_text("\r\n");
    repeat ($urandom_range(0, 3)) begin
      repeat ($urandom_range(0, 5)) push(text_byte(CH_COLON, CH_COLON));
      push(CH_COLON);
      repeat ($urandom_range(0, 8)) push(text_byte(CH_CR, CH_CR));
      push_text("\r\n");
    end
    push_text("\r\n");
    repeat ($urandom_range(0, 8)) push(byte_t'($urandom_range(0, 255)));
    // broken requests: stray line ends or junk, or cut short
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        k = $urandom_range(start, request_beats.size() - 1);
        n = $urandom_range(0, 2);
        request_beats[k].b = n == 0 ? CH_CR : n == 1 ? CH_LF : byte_t'($urandom_range(0, 255));
      end
    end
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, request_beats.size() - start - 1)) void'(request_beats.pop_back());
  endfunction

  task automatic drive_beats();
    beat_t bt;
    while (request_beats.size() != 0) begin
      bt = request_beats.pop_front();
      while (!calm() && $urandom_range(0, 99) < 38) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid      <= 1'b1;
      in_data_byte  <= bt.b;
      in_first_byte <= bt.first;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      sent_cnt++;
      @(negedge clk);
    end
    in_valid <= 1'b0;
  endtask

  // receiver: random stalls, one long hold-off to back up the input
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!held && sent_cnt >= 250) begin
      held      <= 1'b1;
      hold_left <= 120;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm() || ($urandom_range(0, 99) >= 38);
    end
  end

  always @(posedge clk) begin : monitor
    token_t got;
    if (rst_n) begin
      if (in_valid && in_ready) sb.tokenize(in_data_byte, in_first_byte);
      if (out_valid && out_ready) begin
        got.data    = out_byte;
        got.kind    = out_byte_kind;
        got.fend    = out_field_end;
        got.ended   = out_ended_field;
        got.version = out_version_number;
        got.hdone   = out_headers_done;
        got.status  = out_status;
        sb.check_beat(got);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("ERROR: timeout with %0d beats outstanding", sb.expected_tokens.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int roll;
    sb = new();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    push("G", 1'b1);
    push(8'hFF);
    push_text(" ?? /-7.256\rx\r\n:\r\n\r\n\n");
    push(8'h00);
    push(CH_LF, 1'b1);
    push_text("\r\n");

    while (request_beats.size() < 1130) begin
      roll = $urandom_range(0, 9);
      if (roll == 0) begin
        roll = $urandom_range(5, 30);
        for (int i = 0; i < roll; i++)
          push(byte_t'($urandom_range(0, 255)),
               i == 0 ? bit'($urandom_range(0, 1)) : ($urandom_range(0, 19) == 0));
      end else begin
        add_request(roll != 1);
      end
    end

    drive_beats();
    while (sb.expected_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
